[design/bat_seq_pkg.sv]
`default_nettype none
package bat_seq_pkg;

	localparam int unsigned NUM_EV = 5;
	localparam int unsigned CFG_INDEX_W = 8;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned MS_W = 16;

	localparam logic [MS_W-1:0] MS_MAX = '1;
	localparam logic [MS_W-1:0] DEBOUNCE_RST = 16'd250;
	localparam logic [MS_W-1:0] PHASE_RST = 16'd5000;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEBOUNCE = 8'd0,
		REG_WAIT     = 8'd1,
		REG_REVERSE  = 8'd2,
		REG_TURN     = 8'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		MODE_OFF     = 3'd0,
		MODE_WAIT    = 3'd1,
		MODE_DRIVE   = 3'd2,
		MODE_REVERSE = 3'd3,
		MODE_TURN    = 3'd4
	} mode_code_t;

	typedef enum logic [4:0] {
		ST_OFF     = 5'b00001,
		ST_WAIT    = 5'b00010,
		ST_DRIVE   = 5'b00100,
		ST_REVERSE = 5'b01000,
		ST_TURN    = 5'b10000
	} seq_state_t;

	localparam int unsigned EV_START  = 0;
	localparam int unsigned EV_FSONAR = 1;
	localparam int unsigned EV_RSONAR = 2;
	localparam int unsigned EV_FIR    = 3;
	localparam int unsigned EV_RIR    = 4;

	// bit0 left fwd, bit1 right fwd, bit2 left rev, bit3 right rev
	localparam logic [3:0] LINES_OFF     = 4'h0;
	localparam logic [3:0] LINES_FORWARD = 4'h3;
	localparam logic [3:0] LINES_REVERSE = 4'hC;
	localparam logic [3:0] LINES_TURN    = 4'h9;

	function automatic logic [MS_W-1:0] sat_inc(input logic [MS_W-1:0] v);
		sat_inc = (v == MS_MAX) ? v : v + 1'b1;
	endfunction

	function automatic mode_code_t mode_of(input seq_state_t s);
		unique case (s)
			ST_OFF:     mode_of = MODE_OFF;
			ST_WAIT:    mode_of = MODE_WAIT;
			ST_DRIVE:   mode_of = MODE_DRIVE;
			ST_REVERSE: mode_of = MODE_REVERSE;
			ST_TURN:    mode_of = MODE_TURN;
			default:    mode_of = MODE_OFF;
		endcase
	endfunction

endpackage
`default_nettype wire

[design/bump_and_turn_robot_sequencer_core.sv]
// the result beat is registered and appears in the cycle after its input beat is accepted
// throughput: one beat per cycle while out_ready holds; the sequencer state
// and the result register update together on each accepted beat
// in_ready stays high while the result register is empty or being drained
// reset (arst_n low, asynchronous): sequencer and motor state off, timers
// and latches cleared, registers 250 / 5000 / 5000 / 5000; result lines not reset
`default_nettype none
module bump_and_turn_robot_sequencer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bat_seq_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [bat_seq_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic                                start_fall,
	input  wire logic                                front_sonar_fall,
	input  wire logic                                rear_sonar_fall,
	input  wire logic                                front_infrared_fall,
	input  wire logic                                rear_infrared_fall,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     left_forward,
	output logic                                     right_forward,
	output logic                                     left_reverse,
	output logic                                     right_reverse,
	output logic [2:0]                               mode
);
	import bat_seq_pkg::*;

	logic [MS_W-1:0] debounce_q, wait_q, reverse_q, turn_q;

	seq_state_t      state_q, state_d;
	logic [MS_W-1:0] phase_q, phase_d;
	logic [MS_W-1:0] lock_q [NUM_EV];
	logic [MS_W-1:0] lock_d [NUM_EV];
	logic [NUM_EV-1:0] latch_q, latch_d;
	logic [3:0]      motor_q, motor_d;

	logic            out_valid_q;
	logic [3:0]      out_lines_q;
	mode_code_t      out_mode_q;

	logic [NUM_EV-1:0] fall;
	logic [NUM_EV-1:0] ev_hit;
	logic [MS_W-1:0] phase_inc;
	logic            in_beat;

	assign cfg_ready = 1'b1;
	assign in_ready  = !out_valid_q || out_ready;
	assign in_beat   = in_valid && in_ready;

	assign fall = {rear_infrared_fall, front_infrared_fall, rear_sonar_fall,
		front_sonar_fall, start_fall};

	// lockout and latch update
	always_comb begin
		logic [MS_W-1:0] inc;
		for (int i = 0; i < NUM_EV; i++) begin
			inc = sat_inc(lock_q[i]);
			ev_hit[i] = fall[i] && (inc > debounce_q);
			lock_d[i] = ev_hit[i] ? '0 : inc;
		end
	end

	assign phase_inc = sat_inc(phase_q);

	// sequencer step
	always_comb begin
		latch_d = latch_q | ev_hit;
		state_d = state_q;
		phase_d = phase_q;
		motor_d = motor_q;
		unique case (state_q)
			ST_OFF: begin
				if (latch_d[EV_START]) begin
					latch_d[EV_START] = 1'b0;
					state_d = ST_WAIT;
					phase_d = '0;
				end
			end
			ST_WAIT: begin
				phase_d = phase_inc;
				if (phase_inc >= wait_q) begin
					state_d = ST_DRIVE;
					phase_d = '0;
					motor_d = LINES_FORWARD;
				end
			end
			ST_DRIVE: begin
				if (latch_d[EV_FSONAR] || latch_d[EV_FIR]) begin
					latch_d[EV_FSONAR] = 1'b0;
					latch_d[EV_FIR] = 1'b0;
					state_d = ST_REVERSE;
					phase_d = '0;
					motor_d = LINES_REVERSE;
				end
			end
			ST_REVERSE: begin
				phase_d = phase_inc;
				if (phase_inc >= reverse_q || latch_d[EV_RSONAR] || latch_d[EV_RIR]) begin
					latch_d[EV_RSONAR] = 1'b0;
					latch_d[EV_RIR] = 1'b0;
					state_d = ST_TURN;
					phase_d = '0;
					motor_d = LINES_TURN;
				end
			end
			ST_TURN: begin
				phase_d = phase_inc;
				if (phase_inc >= turn_q) begin
					state_d = ST_DRIVE;
					phase_d = '0;
					motor_d = LINES_FORWARD;
				end
			end
			default: begin
				state_d = ST_OFF;
				phase_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			wait_q     <= PHASE_RST;
			reverse_q  <= PHASE_RST;
			turn_q     <= PHASE_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_WAIT:     wait_q     <= cfg_data;
				REG_REVERSE:  reverse_q  <= cfg_data;
				REG_TURN:     turn_q     <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_OFF;
			phase_q <= '0;
			latch_q <= '0;
			motor_q <= LINES_OFF;
			for (int i = 0; i < NUM_EV; i++) begin
				lock_q[i] <= '0;
			end
		end else if (in_beat) begin
			state_q <= state_d;
			phase_q <= phase_d;
			latch_q <= latch_d;
			motor_q <= motor_d;
			for (int i = 0; i < NUM_EV; i++) begin
				lock_q[i] <= lock_d[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_beat) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_beat) begin
			out_lines_q <= motor_d;
			out_mode_q  <= mode_of(state_d);
		end
	end

	assign out_valid     = out_valid_q;
	assign left_forward  = out_lines_q[0];
	assign right_forward = out_lines_q[1];
	assign left_reverse  = out_lines_q[2];
	assign right_reverse = out_lines_q[3];
	assign mode          = out_mode_q;

`ifndef SYNTH
	a_drive_lines: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DRIVE |-> motor_q == LINES_FORWARD)
		else $error("drive state without forward lines");

	a_off_phase: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OFF |-> phase_q == '0)
		else $error("phase timer running while off");

	a_beat_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> out_valid_q)
		else $error("accepted beat produced no result");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!in_beat |=> $stable(state_q) && $stable(latch_q))
		else $error("sequencer moved without an input beat");
`endif
endmodule
`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 100ps
module tb_top;
	import bat_seq_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 600000;
	localparam int unsigned SAT_TICKS = 100;
	localparam int unsigned RANDOM_PHASES = 12;
	localparam int unsigned PHASE_TICKS = 95;
	localparam int unsigned RESET_ROWS = 3;
	localparam int unsigned DIR_ROW_COUNT = 22;
	localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = '1;

	localparam logic [NUM_EV-1:0] F_NONE   = '0;
	localparam logic [NUM_EV-1:0] F_ALL    = '1;
	localparam logic [NUM_EV-1:0] F_START  = NUM_EV'(1) << EV_START;
	localparam logic [NUM_EV-1:0] F_FSONAR = NUM_EV'(1) << EV_FSONAR;
	localparam logic [NUM_EV-1:0] F_RSONAR = NUM_EV'(1) << EV_RSONAR;
	localparam logic [NUM_EV-1:0] F_FIR    = NUM_EV'(1) << EV_FIR;
	localparam logic [NUM_EV-1:0] F_RIR    = NUM_EV'(1) << EV_RIR;

	typedef struct packed {
		logic [3:0] lines;
		mode_code_t mode;
	} motor_state_t;

	typedef struct packed {
		logic [NUM_EV-1:0] flags;
		logic              typed;
		logic [3:0]        lines;
		mode_code_t        mode;
	} tick_row_t;

	// first rows run with reset settings, the rest after a fast setting
	localparam tick_row_t DIR_ROWS [DIR_ROW_COUNT] = '{
		'{F_NONE,           1'b1, LINES_OFF, MODE_OFF},
		'{F_ALL,            1'b1, LINES_OFF, MODE_OFF},
		'{F_START,          1'b1, LINES_OFF, MODE_OFF},
		'{F_START,          1'b1, LINES_OFF, MODE_WAIT},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_RSONAR,         1'b0, LINES_OFF, MODE_OFF},
		'{F_FSONAR,         1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_FIR,            1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_RIR,            1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_FSONAR | F_FIR, 1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF},
		'{F_START,          1'b0, LINES_OFF, MODE_OFF},
		'{F_ALL,            1'b0, LINES_OFF, MODE_OFF},
		'{F_NONE,           1'b0, LINES_OFF, MODE_OFF}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic start_fall = 1'b0;
	logic front_sonar_fall = 1'b0;
	logic rear_sonar_fall = 1'b0;
	logic front_infrared_fall = 1'b0;
	logic rear_infrared_fall = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic left_forward;
	logic right_forward;
	logic left_reverse;
	logic right_reverse;
	logic [2:0] mode;

	// typed expectation that travels with the input beat
	logic row_typed = 1'b0;
	logic [3:0] row_lines = LINES_OFF;
	mode_code_t row_mode = MODE_OFF;

	int unsigned gap_max = 11;
	int unsigned stall_max = 11;
	int unsigned ready_hold = 0;
	int unsigned cycle_count = 0;
	int unsigned fail_count = 0;

	motor_state_t motor_q [$];

	// sequencer copy
	logic [MS_W-1:0] debounce_lim = DEBOUNCE_RST;
	logic [MS_W-1:0] wait_lim = PHASE_RST;
	logic [MS_W-1:0] reverse_lim = PHASE_RST;
	logic [MS_W-1:0] turn_lim = PHASE_RST;
	mode_code_t seq_mode = MODE_OFF;
	logic [MS_W-1:0] phase_ms = '0;
	logic [MS_W-1:0] since_edge [NUM_EV] = '{default: '0};
	logic [NUM_EV-1:0] pending_ev = '0;
	logic [3:0] drive_lines = LINES_OFF;

	bump_and_turn_robot_sequencer_core u_dut (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cfg_valid           (cfg_valid),
		.cfg_ready           (cfg_ready),
		.cfg_index           (cfg_index),
		.cfg_data            (cfg_data),
		.in_valid            (in_valid),
		.in_ready            (in_ready),
		.start_fall          (start_fall),
		.front_sonar_fall    (front_sonar_fall),
		.rear_sonar_fall     (rear_sonar_fall),
		.front_infrared_fall (front_infrared_fall),
		.rear_infrared_fall  (rear_infrared_fall),
		.out_valid           (out_valid),
		.out_ready           (out_ready),
		.left_forward        (left_forward),
		.right_forward       (right_forward),
		.left_reverse        (left_reverse),
		.right_reverse       (right_reverse),
		.mode                (mode)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic phase_done(input logic [MS_W-1:0] lim);
		if (phase_ms != MS_MAX) phase_ms = phase_ms + 1'b1;
		return phase_ms >= lim;
	endfunction

	function automatic void enter_mode(input mode_code_t m, input logic [3:0] l);
		seq_mode = m;
		phase_ms = '0;
		drive_lines = l;
	endfunction

	function automatic motor_state_t step_sequencer(input logic [NUM_EV-1:0] flags);
		motor_state_t res;
		logic timed_out;
		for (int i = 0; i < NUM_EV; i++) begin
			if (since_edge[i] != MS_MAX) since_edge[i] = since_edge[i] + 1'b1;
			if (flags[i] && since_edge[i] > debounce_lim) begin
				since_edge[i] = '0;
				pending_ev[i] = 1'b1;
			end
		end
		case (seq_mode)
			MODE_OFF: begin
				if (pending_ev[EV_START]) begin
					pending_ev[EV_START] = 1'b0;
					seq_mode = MODE_WAIT;
					phase_ms = '0;
				end
			end
			MODE_WAIT: begin
				if (phase_done(wait_lim)) enter_mode(MODE_DRIVE, LINES_FORWARD);
			end
			MODE_DRIVE: begin
				if (pending_ev[EV_FSONAR] || pending_ev[EV_FIR]) begin
					pending_ev[EV_FSONAR] = 1'b0;
					pending_ev[EV_FIR] = 1'b0;
					enter_mode(MODE_REVERSE, LINES_REVERSE);
				end
			end
			MODE_REVERSE: begin
				timed_out = phase_done(reverse_lim);
				if (timed_out || pending_ev[EV_RSONAR] || pending_ev[EV_RIR]) begin
					pending_ev[EV_RSONAR] = 1'b0;
					pending_ev[EV_RIR] = 1'b0;
					enter_mode(MODE_TURN, LINES_TURN);
				end
			end
			MODE_TURN: begin
				if (phase_done(turn_lim)) enter_mode(MODE_DRIVE, LINES_FORWARD);
			end
			default: begin
				seq_mode = MODE_OFF;
				phase_ms = '0;
			end
		endcase
		res.lines = drive_lines;
		res.mode = seq_mode;
		return res;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= 40)
				$display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
		end
	endfunction

	function automatic logic [MS_W-1:0] pick_timer();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return MS_W'(1);
			default: return MS_W'($urandom_range(2, 30));
		endcase
	endfunction

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// result side may stall, for a random time or not at all, after each beat
	always @(posedge clk) begin
		if (out_valid && out_ready) ready_hold = $urandom_range(0, stall_max);
		if (ready_hold > 0) begin
			ready_hold--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		motor_state_t want;
		logic [NUM_EV-1:0] seen;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEBOUNCE: debounce_lim = cfg_data;
					REG_WAIT:     wait_lim = cfg_data;
					REG_REVERSE:  reverse_lim = cfg_data;
					REG_TURN:     turn_lim = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				seen[EV_START] = start_fall;
				seen[EV_FSONAR] = front_sonar_fall;
				seen[EV_RSONAR] = rear_sonar_fall;
				seen[EV_FIR] = front_infrared_fall;
				seen[EV_RIR] = rear_infrared_fall;
				want = step_sequencer(seen);
				if (row_typed) begin
					want.lines = row_lines;
					want.mode = row_mode;
				end
				motor_q.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (motor_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 40)
						$display("%0t ns: result beat with nothing expected, mode %0d",
							$time, mode);
				end else begin
					want = motor_q.pop_front();
					check_field("left_forward", want.lines[0], left_forward);
					check_field("right_forward", want.lines[1], right_forward);
					check_field("left_reverse", want.lines[2], left_reverse);
					check_field("right_reverse", want.lines[3], right_reverse);
					check_field("mode", want.mode, mode);
				end
			end
		end
	end

	task automatic send_tick(input logic [NUM_EV-1:0] flags, input logic typed,
			input logic [3:0] lines, input mode_code_t m);
		int unsigned gap;
		gap = $urandom_range(0, gap_max);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start_fall <= flags[EV_START];
		front_sonar_fall <= flags[EV_FSONAR];
		rear_sonar_fall <= flags[EV_RSONAR];
		front_infrared_fall <= flags[EV_FIR];
		rear_infrared_fall <= flags[EV_RIR];
		row_typed <= typed;
		row_lines <= lines;
		row_mode <= m;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (motor_q.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] d);
		cfg_index <= idx;
		cfg_data <= d;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic program_regs(input logic [MS_W-1:0] lock, input logic [MS_W-1:0] wt,
			input logic [MS_W-1:0] rev, input logic [MS_W-1:0] trn);
		cfg_write(REG_DEBOUNCE, lock);
		cfg_write(REG_WAIT, wt);
		cfg_write(REG_REVERSE, rev);
		cfg_write(REG_TURN, trn);
		cfg_write(REG_UNMAPPED, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [NUM_EV-1:0] flags;
		logic [MS_W-1:0] lock_pick;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROW_COUNT; i++) begin
			if (i == RESET_ROWS) begin
				drain_results();
				program_regs('0, MS_W'(2), MS_W'(3), MS_W'(2));
			end
			send_tick(DIR_ROWS[i].flags, DIR_ROWS[i].typed, DIR_ROWS[i].lines,
				DIR_ROWS[i].mode);
		end

		// full rate run with every limit at maximum, nothing gets through
		drain_results();
		program_regs(MS_MAX, MS_MAX, MS_MAX, MS_MAX);
		gap_max = 0;
		stall_max = 0;
		repeat (SAT_TICKS) send_tick(NUM_EV'($urandom), 1'b0, LINES_OFF, MODE_OFF);

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			drain_results();
			case ($urandom_range(0, 3))
				0: lock_pick = '0;
				1: lock_pick = MS_W'($urandom_range(1, 8));
				default: lock_pick = MS_W'($urandom_range(9, 60));
			endcase
			if (ph == 0) lock_pick = MS_MAX - 1'b1;
			program_regs(lock_pick, pick_timer(), pick_timer(), pick_timer());
			gap_max = (ph % 3 == 1) ? 0 : 11;
			stall_max = (ph % 4 == 2) ? 0 : 11;
			repeat (PHASE_TICKS) begin
				if ($urandom_range(0, 60) == 0) drain_results();
				if ($urandom_range(0, 9) == 0) begin
					flags = NUM_EV'($urandom);
				end else begin
					for (int b = 0; b < NUM_EV; b++) flags[b] = ($urandom_range(0, 5) == 0);
				end
				send_tick(flags, 1'b0, LINES_OFF, MODE_OFF);
			end
		end

		drain_results();
		repeat (4) @(posedge clk);
		if (fail_count == 0 && motor_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

[sim.f]
design/bat_seq_pkg.sv
design/bump_and_turn_robot_sequencer_core.sv
sim/tb_top.sv
